FILE: hw/rtl/wsdpm_pkg.sv
// Shared types and constants for the wildcard star/dot pattern matcher.
package wsdpm_pkg;

    // Pattern storage geometry
    localparam int WORD_COUNT = 4;
    localparam int WORD_W     = 64;
    localparam int CHAR_W     = 8;
    localparam int CHARS_HELD = WORD_COUNT * WORD_W / CHAR_W;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;

    // Special pattern characters
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4
    } t_cfg_index;

    // Pattern view of one cell
    typedef struct packed {
        logic [CHAR_W-1:0] c;          // pattern char j-1
        logic [CHAR_W-1:0] prior;      // pattern char j-2
        logic              has_before; // j >= 2
        logic              en;         // j <= pattern length
    } t_cell_pat;

    // Row control broadcast to every cell
    typedef struct packed {
        logic [CHAR_W-1:0] ch;       // current text byte
        logic              at_start; // use start row as previous row
        logic              step;     // store new row
        logic              clear;    // text finished, zero the row
    } t_row_ctrl;

endpackage

FILE: hw/rtl/wildcard_star_dot_pattern_matcher.sv
// Top level of the wildcard star/dot pattern matcher.
//
// Usage: load the pattern through the write port (index 0 length, 1..4 the
// pattern words, lowest byte first), then stream text one byte per word on
// the input channel. Mark the final byte with i_last_char, or send one word
// with i_empty_text for an empty text. Each such word yields one result
// word on the output channel: o_full_match is 1 when the whole text matches
// the whole pattern. Other bytes yield nothing.
// Throughput: one byte per cycle unless stalled. The new match row is formed
// by a combinational row of PATTERN_MAX cells; a star column waits on the column
// two places back, so the critical path is a ripple of up to PATTERN_MAX/2 cells.
// Latency: the result is registered and is valid the cycle after the
// final byte is taken.
// Reset: pattern length and words clear to zero, the match row clears and
// the next byte starts a new text. No result is pending.
// Stall: while a result waits and i_out_stall is high, o_in_stall is high;
// otherwise a byte is taken every cycle that i_in_valid is high.
module wildcard_star_dot_pattern_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wsdpm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wsdpm_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [wsdpm_pkg::CHAR_W-1:0]         i_text_char,
    input  logic                                 i_last_char,
    input  logic                                 i_empty_text,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_full_match
);
    import wsdpm_pkg::*;

    localparam int IDX_W = (PATTERN_MAX < 1) ? 1 : $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0]  r_len;
    logic [WORD_W-1:0] r_words [WORD_COUNT];
    logic              r_at_start;
    logic              r_out_valid;
    logic              r_full_match;

    logic              w_in_acc;
    logic              w_done;
    logic [IDX_W-1:0]  w_len;
    logic              w_result;
    t_row_ctrl         w_ctrl;
    logic [PATTERN_MAX:0] w_prev;
    logic [PATTERN_MAX:0] w_start;
    logic [PATTERN_MAX:0] w_new;

    // Handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_done     = i_last_char || i_empty_text;

    // Effective pattern length, clamped
    assign w_len = (r_len > LEN_W'(PATTERN_MAX)) ? IDX_W'(PATTERN_MAX) : r_len[IDX_W-1:0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int k = 0; k < WORD_COUNT; k++) begin
                r_words[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_len      <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_WORD_0: r_words[0] <= i_cfg_data;
                CFG_PATTERN_WORD_1: r_words[1] <= i_cfg_data;
                CFG_PATTERN_WORD_2: r_words[2] <= i_cfg_data;
                CFG_PATTERN_WORD_3: r_words[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Row control broadcast
    assign w_ctrl.ch       = i_text_char;
    assign w_ctrl.at_start = r_at_start;
    assign w_ctrl.step     = w_in_acc && !w_done;
    assign w_ctrl.clear    = w_in_acc && w_done;

    // Column zero: empty prefix matches only at text start
    assign w_start[0] = 1'b1;
    assign w_new[0]   = 1'b0;
    assign w_prev[0]  = r_at_start;

    // Row of cells, column j covers pattern prefix of length j
    for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
        t_cell_pat w_pat;
        logic      w_start_l2;
        logic      w_new_l2;

        if (j - 1 < CHARS_HELD) begin : g_char
            assign w_pat.c = r_words[(j-1)/8][((j-1)%8)*8 +: CHAR_W];
        end else begin : g_no_char
            assign w_pat.c = '0;
        end

        if (j >= 2 && j - 2 < CHARS_HELD) begin : g_before
            assign w_pat.prior = r_words[(j-2)/8][((j-2)%8)*8 +: CHAR_W];
        end else begin : g_no_before
            assign w_pat.prior = '0;
        end

        if (j >= 2) begin : g_left2
            assign w_start_l2 = w_start[j-2];
            assign w_new_l2   = w_new[j-2];
        end else begin : g_no_left2
            assign w_start_l2 = 1'b0;
            assign w_new_l2   = 1'b0;
        end

        assign w_pat.has_before = (j >= 2);
        assign w_pat.en         = (w_len >= IDX_W'(j));

        wsdpm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_pat         (w_pat),
            .i_prev_left   (w_prev[j-1]),
            .i_start_left2 (w_start_l2),
            .i_new_left2   (w_new_l2),
            .o_prev        (w_prev[j]),
            .o_start       (w_start[j]),
            .o_new         (w_new[j])
        );
    end

    // Result bit at the full pattern length
    assign w_result = i_empty_text ? w_start[w_len] : w_new[w_len];

    // Text start flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else if (w_in_acc) begin
            r_at_start <= w_done;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= w_in_acc && w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_done) begin
            r_full_match <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_full_match = r_full_match;

`ifndef SYNTHESIS
    // A finished text shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_done) |=> o_out_valid)
        else $error("result missing after final byte");

    // A mid-text byte never produces a result
    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_done && !o_in_stall) |=> !o_out_valid)
        else $error("result after non-final byte");

    // A finished text restarts from the start row
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_done) |=> r_at_start)
        else $error("row not returned to start");

    // A stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_full_match)))
        else $error("stalled result changed");
`endif

endmodule

FILE: hw/rtl/wsdpm_cell.sv
// One column of the match row: holds one match bit and computes its next value.
module wsdpm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wsdpm_pkg::t_row_ctrl  i_ctrl,
    input  wsdpm_pkg::t_cell_pat  i_pat,
    input  logic                  i_prev_left,   // previous row, column j-1
    input  logic                  i_start_left2, // start row, column j-2
    input  logic                  i_new_left2,   // new row, column j-2
    output logic                  o_prev,
    output logic                  o_start,
    output logic                  o_new
);
    import wsdpm_pkg::*;

    logic r_bit;
    logic w_is_star;
    logic w_char_hit;
    logic w_before_hit;

    // Character compares
    assign w_is_star    = (i_pat.c == STAR_CHAR);
    assign w_char_hit   = (i_pat.c == DOT_CHAR) || (i_pat.c == i_ctrl.ch);
    assign w_before_hit = (i_pat.prior == DOT_CHAR) || (i_pat.prior == i_ctrl.ch);

    // Start row: a star carries the bit two columns back
    assign o_start = i_pat.en && w_is_star && i_pat.has_before && i_start_left2;

    // Previous row as seen by this byte
    assign o_prev = i_ctrl.at_start ? o_start : r_bit;

    // New row: star ORs zero copies with one more copy; else diagonal step
    always_comb begin
        if (!i_pat.en) begin
            o_new = 1'b0;
        end else if (w_is_star) begin
            o_new = i_pat.has_before && (i_new_left2 || (w_before_hit && o_prev));
        end else begin
            o_new = w_char_hit && i_prev_left;
        end
    end

    // Stored match bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.step) begin
            r_bit <= o_new;
        end
    end

endmodule
